/* design/kct_pkg.sv */
// Shared types, constants and helpers for the keyed cover table.
// Used by the top level, the compare unit and the checker; kct_ram stands alone.
package kct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W   = 16;
    localparam int TIME_W  = 40;
    localparam int EXP_W   = TIME_W + 1;
    localparam int OCC_W   = 5;
    localparam int OCC_MAX = (1 << OCC_W) - 1;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_EXPIRE = 2'd2,
        CMD_LOOKUP = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [9:0]        country_id;
        logic [5:0]        marker_id;
        logic [TIME_W-1:0] start_ms;
        logic [TIME_W-1:0] valid_for_ms;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic             status;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [EXP_W-1:0] expiry;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic key_eq;
        logic expired;
    } t_cmp_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Clamp an entry count to what the occupancy field can show.
    function automatic logic [OCC_W-1:0] sat_occ(logic [CNT_W-1:0] c);
        logic [OCC_W-1:0] r;
        if (32'(c) > 32'(OCC_MAX)) begin
            r = OCC_W'(OCC_MAX);
        end else begin
            r = OCC_W'(c);
        end
        return r;
    endfunction

endpackage

/* design/kct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/kct_cmp.sv */
// Shared compare unit: key equality and expiry test on one stored entry.
// Depends on kct_pkg.
module kct_cmp (
    input  kct_pkg::t_entry                i_entry,
    input  logic [kct_pkg::KEY_W-1:0]      i_key,
    input  logic [kct_pkg::TIME_W-1:0]     i_now,
    output kct_pkg::t_cmp_res              o_res
);
    import kct_pkg::*;

    always_comb begin
        o_res.key_eq  = (i_entry.key == i_key);
        // expiry equal to now counts as expired
        o_res.expired = (i_entry.expiry <= {1'b0, i_now});
    end

endmodule

/* design/keyed_cover_table_with_expiry.sv */
// Top level of the keyed cover table: sequencer, valid bits and counters.
// Depends on kct_pkg, kct_ram and kct_cmp.
//
// For each command the sequencer walks the entry memory one entry per
// cycle through its single registered read port and the one shared
// compare unit, then, in its finish state, places a new entry for a set
// command if a slot is free and forms the result. busy is high from the
// cycle after acceptance until the result shows; o_result holds the result
// until the next one, o_done marks it for exactly one cycle and cannot be
// held off, so capture it then. busy is already low in that cycle, so the
// next command may be started there.
module keyed_cover_table_with_expiry (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  kct_pkg::t_in_item  i_item,
    output logic               o_done,
    output kct_pkg::t_out_item o_result
);
    import kct_pkg::*;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [EXP_W-1:0]   r_expiry, n_expiry;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [CNT_W-1:0]   r_issue, n_issue;
    logic               r_chk_pend, n_chk_pend;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic               r_hit, n_hit;
    logic               r_slot_found, n_slot_found;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic               r_done, n_done;
    t_out_item          r_result, n_result;

    t_entry             rd_entry;
    t_entry             wr_entry;
    logic               ram_we;
    logic [IDX_W-1:0]   rd_addr;
    t_cmp_res           cmp;

    logic               ent_live;
    logic               key_match;
    logic               do_clear;
    logic               is_free;
    logic               accept;
    logic [CNT_W-1:0]   occ_after;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    assign rd_addr        = r_issue[IDX_W-1:0];
    assign wr_entry.key    = r_key;
    assign wr_entry.expiry = r_expiry;
    assign ram_we = (r_state == ST_FINISH) && (r_cmd == CMD_SET) && r_slot_found;

    kct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    kct_cmp u_cmp (
        .i_entry (rd_entry),
        .i_key   (r_key),
        .i_now   (r_now),
        .o_res   (cmp)
    );

    always_comb begin
        ent_live  = r_chk_pend && r_valid[r_chk_idx];
        key_match = ent_live && cmp.key_eq;
        case (r_cmd)
            CMD_SET, CMD_REMOVE: do_clear = key_match;
            CMD_EXPIRE:          do_clear = ent_live && cmp.expired;
            default:             do_clear = 1'b0;
        endcase
        // a slot is free once any same-key entry in it has been dropped
        is_free   = r_chk_pend && (!r_valid[r_chk_idx] || key_match);
        occ_after = r_occ + CNT_W'(ram_we);
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_expiry     = r_expiry;
        n_now        = r_now;
        n_issue      = r_issue;
        n_chk_pend   = r_chk_pend;
        n_chk_idx    = r_chk_idx;
        n_valid      = r_valid;
        n_occ        = r_occ;
        n_hit        = r_hit;
        n_slot_found = r_slot_found;
        n_slot       = r_slot;
        n_done       = 1'b0;
        n_result     = r_result;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd        = i_item.command;
                    n_key        = {i_item.country_id, i_item.marker_id};
                    n_expiry     = {1'b0, i_item.start_ms} + {1'b0, i_item.valid_for_ms};
                    n_now        = i_item.now_ms;
                    n_issue      = '0;
                    n_chk_pend   = 1'b0;
                    n_hit        = 1'b0;
                    n_slot_found = 1'b0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue the next read while checking the entry read last cycle
                if (32'(r_issue) != TABLE_ENTRIES) begin
                    n_issue    = r_issue + 1'b1;
                    n_chk_pend = 1'b1;
                    n_chk_idx  = r_issue[IDX_W-1:0];
                end else begin
                    n_chk_pend = 1'b0;
                    if (!r_chk_pend) begin
                        n_state = ST_FINISH;
                    end
                end
                if (key_match) begin
                    n_hit = 1'b1;
                end
                if (do_clear) begin
                    n_valid[r_chk_idx] = 1'b0;
                    n_occ              = r_occ - 1'b1;
                end
                if ((r_cmd == CMD_SET) && is_free && !r_slot_found) begin
                    n_slot_found = 1'b1;
                    n_slot       = r_chk_idx;
                end
            end
            ST_FINISH: begin
                if (ram_we) begin
                    n_valid[r_slot] = 1'b1;
                end
                n_occ              = occ_after;
                n_done             = 1'b1;
                n_result.hit       = r_hit;
                n_result.status    = (r_cmd == CMD_SET) && !r_slot_found;
                n_result.occupancy = sat_occ(occ_after);
                n_state            = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_occ      <= '0;
            r_done     <= 1'b0;
            r_chk_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_occ      <= n_occ;
            r_done     <= n_done;
            r_chk_pend <= n_chk_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_expiry     <= n_expiry;
        r_now        <= n_now;
        r_issue      <= n_issue;
        r_chk_idx    <= n_chk_idx;
        r_hit        <= n_hit;
        r_slot_found <= n_slot_found;
        r_slot       <= n_slot;
        r_result     <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* design/kct_chk.sv */
// Port-level checker for the keyed cover table, bound to the top level.
// Depends on kct_pkg.
module kct_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input kct_pkg::t_in_item  i_item,
    input logic               o_done,
    input kct_pkg::t_out_item o_result
);
    import kct_pkg::*;

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // a result only follows a busy stretch
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // a dropped insert means the table is full and the key was absent
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status) |->
            (!o_result.hit &&
             o_result.occupancy == sat_occ(CNT_W'(TABLE_ENTRIES))))
        else $error("insert dropped while table not full");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_result.occupancy) <= TABLE_ENTRIES))
        else $error("occupancy above table size");

endmodule

bind keyed_cover_table_with_expiry kct_chk u_kct_chk (.*);
